@@ rtl/core/sitda_pkg.sv @@
// Package for the signed integer to decimal ASCII unit.
// Holds the shared constants, the pipeline record types and the double-dabble step.
// Depends on nothing.

package sitda_pkg;

	localparam int unsigned VALUE_W      = 32;
	localparam int unsigned NUM_DIGITS   = 10;
	localparam int unsigned BCD_W        = 4 * NUM_DIGITS;
	localparam int unsigned DABBLE_STEPS = 8;
	localparam int unsigned DABBLE_STAGES = VALUE_W / DABBLE_STEPS;

	localparam logic [7:0] ASCII_ZERO  = 8'd48;
	localparam logic [7:0] ASCII_MINUS = 8'd45;

	// Conversion state that travels down the double-dabble stages.
	typedef struct packed {
		logic               neg;
		logic [BCD_W-1:0]   bcd;
		logic [VALUE_W-1:0] bin;
	} sitda_dab_t;

	// A converted number, ready to be sent out one character per beat.
	typedef struct packed {
		logic             neg;
		logic [3:0]       top;
		logic [BCD_W-1:0] bcd;
	} sitda_item_t;

	// Eight shift-and-add-three steps of the binary to BCD conversion.
	function automatic sitda_dab_t dabble8(input sitda_dab_t d);
		sitda_dab_t r;
		r = d;
		for (int s = 0; s < DABBLE_STEPS; s++) begin
			for (int k = 0; k < NUM_DIGITS; k++) begin
				if (r.bcd[4*k +: 4] >= 4'd5) begin
					r.bcd[4*k +: 4] = r.bcd[4*k +: 4] + 4'd3;
				end
			end
			{r.bcd, r.bin} = {r.bcd[BCD_W-2:0], r.bin, 1'b0};
		end
		return r;
	endfunction

endpackage

@@ rtl/core/sitda_if.sv @@
// Stream interfaces of the signed integer to decimal ASCII unit.
// One interface for the number channel and one for the character channel.
// Depends on nothing.

interface sitda_num_if;
	logic        valid;
	logic        ready;
	logic [31:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface sitda_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last;

	modport source (output valid, output character, output last, input ready);
	modport sink (input valid, input character, input last, output ready);
endinterface

@@ rtl/core/signed_int_to_decimal_ascii_unit.sv @@
// Top level of the signed integer to decimal ASCII unit.
// Negation stage, four double-dabble stages, digit count stage, then the serializer.
// Depends on sitda_pkg, sitda_if and sitda_serializer.

// The unit takes one signed 32-bit number per beat on num and sends its
// decimal text on chars, one ASCII character per beat, most significant
// digit first, with a leading '-' for negative values and last set on the
// final character. Zero gives the single character '0', and the most
// negative value gives "-2147483648". A number passes the conversion
// registers (negation, four stages of eight shift-and-add-three steps,
// digit count) before its first character can appear. The character
// channel sets the sustained rate: each number holds it for as many
// beats as it has characters, from 1 to 11. While a number is being
// sent, up to six further numbers are taken into the conversion
// pipeline, and the next number's first character follows the
// previous number's last character without a gap. Back pressure on
// chars stalls the pipeline without losing or repeating anything.
// Every number is independent of the ones before it.

module signed_int_to_decimal_ascii_unit
	import sitda_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	sitda_num_if.sink    num,
	sitda_char_if.source chars
);

	// Stage 1: sign and magnitude. The magnitude is taken modulo 2^32, so
	// the most negative value keeps its magnitude 2^31 as an unsigned word.
	logic       vld_s1;
	logic       rdy_s1;
	sitda_dab_t dab_s1;

	// Stages 2 to 5: double dabble, eight input bits per stage.
	logic [DABBLE_STAGES-1:0] dab_vld_s;
	logic [DABBLE_STAGES-1:0] dab_rdy_s;
	sitda_dab_t               dab_s [DABBLE_STAGES];

	// Stage 6: position of the most significant nonzero digit.
	logic        vld_s6;
	logic        rdy_s6;
	sitda_item_t item_s6;
	logic [3:0]  top;

	logic        ser_ready;

	assign rdy_s1    = !vld_s1 || dab_rdy_s[0];
	assign num.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= num.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && num.valid) begin
			dab_s1.neg <= num.value[VALUE_W-1];
			dab_s1.bcd <= '0;
			dab_s1.bin <= num.value[VALUE_W-1] ? (VALUE_W'(0) - num.value) : num.value;
		end
	end

	// Each conversion stage advances when the one after it can take its beat.
	for (genvar i = 0; i < DABBLE_STAGES; i++) begin : g_dab
		logic       prev_vld;
		logic       next_rdy;
		sitda_dab_t prev;

		if (i == 0) begin : g_first
			assign prev_vld = vld_s1;
			assign prev     = dab_s1;
		end else begin : g_mid
			assign prev_vld = dab_vld_s[i-1];
			assign prev     = dab_s[i-1];
		end

		if (i == DABBLE_STAGES - 1) begin : g_last
			assign next_rdy = rdy_s6;
		end else begin : g_inner
			assign next_rdy = dab_rdy_s[i+1];
		end

		assign dab_rdy_s[i] = !dab_vld_s[i] || next_rdy;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dab_vld_s[i] <= 1'b0;
			end else if (dab_rdy_s[i]) begin
				dab_vld_s[i] <= prev_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (dab_rdy_s[i] && prev_vld) begin
				dab_s[i] <= dabble8(prev);
			end
		end
	end

	// The highest nonzero digit sets the text length; zero keeps one digit.
	always_comb begin
		top = 4'd0;
		for (int k = 1; k < NUM_DIGITS; k++) begin
			if (dab_s[DABBLE_STAGES-1].bcd[4*k +: 4] != 4'd0) begin
				top = 4'(k);
			end
		end
	end

	assign rdy_s6 = !vld_s6 || ser_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (rdy_s6) begin
			vld_s6 <= dab_vld_s[DABBLE_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s6 && dab_vld_s[DABBLE_STAGES-1]) begin
			item_s6.neg <= dab_s[DABBLE_STAGES-1].neg;
			item_s6.top <= top;
			item_s6.bcd <= dab_s[DABBLE_STAGES-1].bcd;
		end
	end

	sitda_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (vld_s6),
		.item_ready (ser_ready),
		.item       (item_s6),
		.chars      (chars)
	);

endmodule

@@ rtl/core/sitda_serializer.sv @@
// Character serializer of the signed integer to decimal ASCII unit.
// Turns one converted number into a run of character beats, sign first.
// Depends on sitda_pkg and sitda_char_if.

module sitda_serializer
	import sitda_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  sitda_item_t        item,
	sitda_char_if.source       chars
);

	logic             busy_q;
	logic             sign_q;
	logic [3:0]       idx_q;
	logic [BCD_W-1:0] bcd_q;
	logic [3:0]       digit;
	logic             fire;
	logic             load;

	assign digit = bcd_q[idx_q*4 +: 4];

	assign chars.valid     = busy_q;
	assign chars.character = sign_q ? ASCII_MINUS : (ASCII_ZERO + {4'd0, digit});
	assign chars.last      = !sign_q && (idx_q == 4'd0);

	assign fire       = chars.valid && chars.ready;
	// A new number may load in the same cycle that the final character leaves.
	assign item_ready = !busy_q || (fire && chars.last);
	assign load       = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sign_q <= 1'b0;
			idx_q  <= 4'd0;
		end else if (load) begin
			busy_q <= 1'b1;
			sign_q <= item.neg;
			idx_q  <= item.top;
		end else if (fire) begin
			if (sign_q) begin
				sign_q <= 1'b0;
			end else if (idx_q == 4'd0) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bcd_q <= item.bcd;
		end
	end

endmodule

@@ dv/signed_int_to_decimal_ascii_unit_test.sv @@
// Testbench for signed_int_to_decimal_ascii_unit: drives numbers and checks the decimal text.
// Expected characters come from a behavioral converter kept in this file.
// Depends on sitda_pkg, sitda_if and the unit itself.

module signed_int_to_decimal_ascii_unit_test;
	import sitda_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// A cycle with no beat on either channel counts toward the watchdog. The
	// longest honest quiet stretch is a long sender gap followed by the
	// pipeline fill, or a long receiver stall.
	localparam int IDLE_LIMIT    = 2000;
	// Quiet cycles allowed after the last expected character, so that a
	// stray character from the conversion pipeline still shows up.
	localparam int TAIL_CYCLES   = 30;
	localparam int RESET_CYCLES  = 11;
	localparam int RANDOM_ITEMS  = 130;
	localparam int NUM_BOUNDARY  = 20;

	// One character beat as the unit should send it.
	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} text_beat_t;

	// One number waiting to be sent, with a flag that makes the sender hold
	// it back until every character of the earlier numbers has arrived.
	typedef struct {
		logic [VALUE_W-1:0] value;
		bit                 drain_first;
	} number_job_t;

	logic clk = 1'b0;
	logic arst_n;

	sitda_num_if  num_bus ();
	sitda_char_if char_bus ();

	signed_int_to_decimal_ascii_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num_bus),
		.chars  (char_bus)
	);

	always #2 clk = ~clk;

	number_job_t number_jobs [$];
	text_beat_t  expected_text [$];

	int fail_count  = 0;
	int idle_cycles = 0;

	// Extreme and boundary values: zero, single digits, every change in digit
	// count that matters, the largest value and the most negative value.
	int boundary_values [NUM_BOUNDARY] = '{
		0, 1, -1, 9, -9, 10, -10, 99, 100, -100,
		12345, -54321, 999999999, -999999999, 1000000000, -1000000000,
		2147483647, 32'h80000000, 32'h80000001, 1999999999
	};

	// Converts one number to the characters the unit must send and queues
	// them. The magnitude is taken at 32 bits unsigned, so the most negative
	// value converts without overflow.
	function automatic void expand_decimal_text(input logic [VALUE_W-1:0] value);
		logic               is_neg;
		logic [VALUE_W-1:0] mag;
		logic [3:0]         digits [NUM_DIGITS];
		int                 count;
		text_beat_t         beat;
		is_neg = value[VALUE_W-1];
		mag    = is_neg ? (32'd0 - value) : value;
		count  = 0;
		// Digits are collected least significant first; zero still gives one.
		do begin
			digits[count] = 4'(mag % 32'd10);
			mag           = mag / 32'd10;
			count++;
		end while (mag != 32'd0);
		if (is_neg) begin
			beat.character = ASCII_MINUS;
			beat.last      = 1'b0;
			expected_text.push_back(beat);
		end
		for (int k = count - 1; k >= 0; k--) begin
			beat.character = ASCII_ZERO + {4'd0, digits[k]};
			beat.last      = (k == 0);
			expected_text.push_back(beat);
		end
	endfunction

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			return 0;
		end else if (roll < 85) begin
			return $urandom_range(1, 3);
		end else if (roll < 96) begin
			return $urandom_range(4, 9);
		end
		return $urandom_range(15, 40);
	endfunction

	// Sender. A number is predicted at the edge where its beat is taken.
	// Gaps are counted in whole cycles with valid low; while in calm mode the
	// sender offers a new number each cycle unless ready or a drain holds it.
	// Valid is set once per edge, so it stays high across back-to-back beats.
	int send_gap  = 0;
	bit send_calm = 1'b0;
	bit offer;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_bus.valid <= 1'b0;
			num_bus.value <= '0;
			send_gap = 0;
		end else begin
			offer = num_bus.valid;
			if (num_bus.valid && num_bus.ready) begin
				expand_decimal_text(num_bus.value);
				offer    = 1'b0;
				send_gap = send_calm ? 0 : pick_gap();
				if ($urandom_range(0, 39) == 0) begin
					send_calm = !send_calm;
				end
			end
			if (!offer) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (number_jobs.size() != 0 &&
						(!number_jobs[0].drain_first || expected_text.size() == 0)) begin
					num_bus.value <= number_jobs[0].value;
					number_jobs.pop_front();
					offer = 1'b1;
				end
			end
			num_bus.valid <= offer;
		end
	end

	// Receiver. Each character beat is checked against the oldest expected
	// character, field by field. Ready drops for random stretches except in
	// calm mode, where every character is taken as soon as it is offered.
	int         stall_left = 0;
	bit         recv_calm  = 1'b0;
	bit         take;
	text_beat_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_bus.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (char_bus.valid && char_bus.ready) begin
				if (expected_text.size() == 0) begin
					$display("%0t: unexpected character, expected none, actual 0x%02h last %b",
						$time, char_bus.character, char_bus.last);
					fail_count++;
				end else begin
					want = expected_text.pop_front();
					if (char_bus.character !== want.character) begin
						$display("%0t: character mismatch, expected 0x%02h, actual 0x%02h",
							$time, want.character, char_bus.character);
						fail_count++;
					end
					if (char_bus.last !== want.last) begin
						$display("%0t: last mismatch on 0x%02h, expected %b, actual %b",
							$time, want.character, want.last, char_bus.last);
						fail_count++;
					end
				end
				if ($urandom_range(0, 59) == 0) begin
					recv_calm = !recv_calm;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				take = 1'b0;
			end else begin
				take = 1'b1;
				if (!recv_calm && $urandom_range(0, 3) == 0) begin
					stall_left = pick_gap();
				end
			end
			char_bus.ready <= take;
		end
	end

	// The watchdog counter restarts on any beat of either channel.
	always @(posedge clk) begin
		if ((num_bus.valid && num_bus.ready) || (char_bus.valid && char_bus.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
		end
		$display("FAIL");
		$finish;
	end

	// Stimulus and end of run. Random numbers are spread evenly over digit
	// counts and signs, so that short and long texts both occur often, with
	// some raw 32-bit words for full bit coverage and some values near the
	// extremes. Twice the sender waits for the unit to drain completely.
	int                 digits_wanted;
	int                 roll;
	bit                 want_neg;
	longint             lo;
	longint             hi;
	logic [VALUE_W-1:0] mag;
	number_job_t        job;

	initial begin
		arst_n = 1'b0;

		for (int i = 0; i < NUM_BOUNDARY; i++) begin
			job.value       = boundary_values[i];
			job.drain_first = 1'b0;
			number_jobs.push_back(job);
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			roll     = $urandom_range(0, 9);
			want_neg = $urandom_range(0, 1);
			if (roll < 2) begin
				job.value = $urandom;
			end else if (roll == 2) begin
				// Just inside the extremes of the signed range.
				mag       = $urandom_range(0, 15);
				job.value = want_neg ? (32'h80000000 + mag) : (32'h7fffffff - mag);
			end else begin
				digits_wanted = $urandom_range(1, NUM_DIGITS);
				lo = 1;
				repeat (digits_wanted - 1) lo = lo * 10;
				hi = lo * 10 - 1;
				if (digits_wanted == 1) begin
					lo = 0;
				end
				if (hi > 64'sd2147483647 + want_neg) begin
					hi = 64'sd2147483647 + want_neg;
				end
				mag       = $urandom_range(hi[31:0], lo[31:0]);
				job.value = want_neg ? (32'd0 - mag) : mag;
			end
			job.drain_first = (i == 0) || (i == RANDOM_ITEMS / 2);
			number_jobs.push_back(job);
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Checked between edges, once the sender's updates have settled.
		while (number_jobs.size() != 0 || num_bus.valid) begin
			@(negedge clk);
		end
		while (expected_text.size() != 0) begin
			@(negedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/sitda_pkg.sv
rtl/core/sitda_if.sv
rtl/core/sitda_serializer.sv
rtl/core/signed_int_to_decimal_ascii_unit.sv
dv/signed_int_to_decimal_ascii_unit_test.sv
